@@ rtl/mf3_pkg.sv @@
`default_nettype none

package mf3_pkg;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_PIXEL_BITS   = 8;

    localparam int WIN_TAPS         = 9;
    localparam int MID_RANK         = 4;
    localparam int WIN_HIST         = 6;

    localparam int CFG_BITS         = 12;
    localparam int CFG_IDX_BITS     = 1;
    localparam int COORD_BITS       = 11;

    localparam int MIN_SIZE         = 3;
    localparam int MAX_HEIGHT       = 2048;
    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    // power of two, pointers wrap on their own
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [COORD_BITS-1:0] center_column;
        logic [COORD_BITS-1:0] center_row;
        logic                  frame_last;
    } t_center;

endpackage

`default_nettype wire

@@ rtl/mf3_if.sv @@
`default_nettype none

interface mf3_pix_if #(parameter int PIXEL_BITS = 8);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface mf3_res_if #(parameter int PIXEL_BITS = 8);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] median_value;
    logic [10:0]           center_column;
    logic [10:0]           center_row;
    logic                  frame_last;

    modport source (output valid, output median_value, output center_column,
                    output center_row, output frame_last, input ready);
    modport sink   (input valid, input median_value, input center_column,
                    input center_row, input frame_last, output ready);
endinterface

interface mf3_cfg_if;
    import mf3_pkg::*;
    logic                valid;
    logic                ready;
    t_cfg_reg            index;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface mf3_win_if #(parameter int PIXEL_BITS = 8);
    import mf3_pkg::*;
    logic                                  valid;
    logic                                  ready;
    logic [WIN_TAPS-1:0][PIXEL_BITS-1:0]   window;
    t_center                               center;

    modport source (output valid, output window, output center, input ready);
    modport sink   (input valid, input window, input center, output ready);
endinterface

`default_nettype wire

@@ rtl/mf3_front.sv @@
`default_nettype none

module mf3_front
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mf3_cfg_if.sink    i_cfg,
    mf3_pix_if.sink    i_pix,
    mf3_win_if.source  o_win
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;
    localparam int RST_W = (DEF_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_IMAGE_WIDTH;

    // geometry, held as last column / last row
    logic [CW-1:0]         r_w_last;
    logic [COORD_BITS-1:0] r_h_last;
    logic [SW-1:0]         cfg_w_ext;
    logic [SW-1:0]         w_clamp;
    logic [CFG_BITS-1:0]   h_clamp;

    logic [CW-1:0]         r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [CW-1:0]         cur_col;
    logic [COORD_BITS-1:0] cur_row;
    logic [CW-1:0]         n_col;
    logic [COORD_BITS-1:0] n_row;
    logic [CW-1:0]         col_m1;
    logic [COORD_BITS-1:0] row_m1;
    logic                  cur_emit;

    logic                  pix_fire;
    logic                  cfg_fire;
    logic                  s1_go;

    logic                  r_s1_valid;
    logic                  r_s1_emit;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [CW-1:0]         r_s1_addr;
    t_center               r_s1_center;

    logic [PIXEL_BITS-1:0] r_line_upper  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_line_middle [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_top_rd;
    logic [PIXEL_BITS-1:0] r_mid_rd;
    logic                  r_byp;
    logic [PIXEL_BITS-1:0] r_byp_top;
    logic [PIXEL_BITS-1:0] r_byp_mid;
    logic [PIXEL_BITS-1:0] top_eff;
    logic [PIXEL_BITS-1:0] mid_eff;

    logic [PIXEL_BITS-1:0] r_win [WIN_HIST];

    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign pix_fire    = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        cfg_w_ext = SW'(i_cfg.data);
        if (cfg_w_ext < SW'(MIN_SIZE)) begin
            w_clamp = SW'(MIN_SIZE);
        end else if (cfg_w_ext > SW'(MAX_WIDTH)) begin
            w_clamp = SW'(MAX_WIDTH);
        end else begin
            w_clamp = cfg_w_ext;
        end
        if (i_cfg.data < CFG_BITS'(MIN_SIZE)) begin
            h_clamp = CFG_BITS'(MIN_SIZE);
        end else if (i_cfg.data > CFG_BITS'(MAX_HEIGHT)) begin
            h_clamp = CFG_BITS'(MAX_HEIGHT);
        end else begin
            h_clamp = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(RST_W - 1);
            r_h_last <= COORD_BITS'(DEF_IMAGE_HEIGHT - 1);
        end else if (cfg_fire) begin
            unique case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_w_last <= CW'(w_clamp - SW'(1));
                CFG_IMAGE_HEIGHT: r_h_last <= COORD_BITS'(h_clamp - CFG_BITS'(1));
            endcase
        end
    end

    // position of the incoming word and where the counters go next
    always_comb begin
        cur_col  = i_pix.frame_start ? '0 : r_col;
        cur_row  = i_pix.frame_start ? '0 : r_row;
        cur_emit = (cur_col >= CW'(2)) && (cur_row >= COORD_BITS'(2)) &&
                   (cur_col <= r_w_last) && (cur_row <= r_h_last);
        col_m1   = cur_col - CW'(1);
        row_m1   = cur_row - COORD_BITS'(1);
        if (cur_col >= r_w_last) begin
            n_col = '0;
            n_row = (cur_row >= r_h_last) ? '0 : cur_row + COORD_BITS'(1);
        end else begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign s1_go       = r_s1_valid && (!r_s1_emit || o_win.ready);
    assign i_pix.ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (pix_fire) begin
            r_s1_valid <= 1'b1;
            // the word leaving now writes the column that is being read
            r_byp      <= s1_go && (r_s1_addr == cur_col);
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_s1_emit                 <= cur_emit;
            r_s1_px                   <= i_pix.pixel_value;
            r_s1_addr                 <= cur_col;
            r_s1_center.center_column <= COORD_BITS'(col_m1);
            r_s1_center.center_row    <= row_m1;
            r_s1_center.frame_last    <= (cur_col == r_w_last) && (cur_row == r_h_last);
            r_byp_top                 <= mid_eff;
            r_byp_mid                 <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_top_rd <= r_line_upper[cur_col];
            r_mid_rd <= r_line_middle[cur_col];
        end
        if (s1_go) begin
            r_line_upper[r_s1_addr]  <= mid_eff;
            r_line_middle[r_s1_addr] <= r_s1_px;
        end
    end

    assign top_eff = r_byp ? r_byp_top : r_top_rd;
    assign mid_eff = r_byp ? r_byp_mid : r_mid_rd;

    // two previous columns, oldest first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_HIST; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_go) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top_eff;
            r_win[4] <= mid_eff;
            r_win[5] <= r_s1_px;
        end
    end

    always_comb begin
        o_win.valid     = r_s1_valid && r_s1_emit;
        o_win.center    = r_s1_center;
        o_win.window[0] = r_win[0];
        o_win.window[1] = r_win[3];
        o_win.window[2] = top_eff;
        o_win.window[3] = r_win[1];
        o_win.window[4] = r_win[4];
        o_win.window[5] = mid_eff;
        o_win.window[6] = r_win[2];
        o_win.window[7] = r_win[5];
        o_win.window[8] = r_s1_px;
    end

endmodule

`default_nettype wire

@@ rtl/mf3_queue.sv @@
`default_nettype none

module mf3_queue
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mf3_win_if.sink    i_win,
    mf3_win_if.source  o_win
);

    localparam int QP = $clog2(QUEUE_DEPTH);

    logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] r_win_slot [QUEUE_DEPTH];
    t_center                             r_ctr_slot [QUEUE_DEPTH];
    logic [QP-1:0]                       r_wr_ptr;
    logic [QP-1:0]                       r_rd_ptr;
    logic [QP:0]                         r_count;
    logic                                push;
    logic                                pop;

    assign i_win.ready  = (r_count != (QP + 1)'(QUEUE_DEPTH));
    assign o_win.valid  = (r_count != '0);
    assign o_win.window = r_win_slot[r_rd_ptr];
    assign o_win.center = r_ctr_slot[r_rd_ptr];

    assign push = i_win.valid && i_win.ready;
    assign pop  = o_win.valid && o_win.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_win_slot[r_wr_ptr] <= i_win.window;
            r_ctr_slot[r_wr_ptr] <= i_win.center;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QP'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QP'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (QP + 1)'(1);
                2'b01:   r_count <= r_count - (QP + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/mf3_back.sv @@
`default_nettype none

module mf3_back
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mf3_win_if.sink    i_win,
    mf3_res_if.source  o_res
);

    logic                  advance;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic [PIXEL_BITS-1:0] r_p1 [WIN_TAPS];
    logic [PIXEL_BITS-1:0] r_p2 [WIN_TAPS];
    logic [PIXEL_BITS-1:0] r_med;
    t_center               r_c1;
    t_center               r_c2;
    t_center               r_c3;
    logic [PIXEL_BITS-1:0] n_p1 [WIN_TAPS];
    logic [PIXEL_BITS-1:0] n_p2 [WIN_TAPS];
    logic [PIXEL_BITS-1:0] n_med;

    // {min, max}
    function automatic logic [2*PIXEL_BITS-1:0] sort2(input logic [PIXEL_BITS-1:0] a,
                                                       input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? {b, a} : {a, b};
    endfunction

    // exchange network for the fifth of nine, three layers per stage
    always_comb begin
        for (int i = 0; i < WIN_TAPS; i++) begin
            n_p1[i] = i_win.window[i];
        end
        {n_p1[1], n_p1[2]} = sort2(n_p1[1], n_p1[2]);
        {n_p1[4], n_p1[5]} = sort2(n_p1[4], n_p1[5]);
        {n_p1[7], n_p1[8]} = sort2(n_p1[7], n_p1[8]);
        {n_p1[0], n_p1[1]} = sort2(n_p1[0], n_p1[1]);
        {n_p1[3], n_p1[4]} = sort2(n_p1[3], n_p1[4]);
        {n_p1[6], n_p1[7]} = sort2(n_p1[6], n_p1[7]);
        {n_p1[1], n_p1[2]} = sort2(n_p1[1], n_p1[2]);
        {n_p1[4], n_p1[5]} = sort2(n_p1[4], n_p1[5]);
        {n_p1[7], n_p1[8]} = sort2(n_p1[7], n_p1[8]);
    end

    always_comb begin
        for (int i = 0; i < WIN_TAPS; i++) begin
            n_p2[i] = r_p1[i];
        end
        {n_p2[0], n_p2[3]} = sort2(n_p2[0], n_p2[3]);
        {n_p2[5], n_p2[8]} = sort2(n_p2[5], n_p2[8]);
        {n_p2[4], n_p2[7]} = sort2(n_p2[4], n_p2[7]);
        {n_p2[3], n_p2[6]} = sort2(n_p2[3], n_p2[6]);
        {n_p2[1], n_p2[4]} = sort2(n_p2[1], n_p2[4]);
        {n_p2[2], n_p2[5]} = sort2(n_p2[2], n_p2[5]);
        {n_p2[4], n_p2[7]} = sort2(n_p2[4], n_p2[7]);
    end

    always_comb begin
        logic [PIXEL_BITS-1:0] a2;
        logic [PIXEL_BITS-1:0] a4;
        logic [PIXEL_BITS-1:0] a6;
        a2 = r_p2[2];
        a4 = r_p2[MID_RANK];
        a6 = r_p2[6];
        {a4, a2} = sort2(a4, a2);
        {a6, a4} = sort2(a6, a4);
        {a4, a2} = sort2(a4, a2);
        n_med = a4;
    end

    // all stages move together, the last one is the output register
    assign advance     = !r_v3 || o_res.ready;
    assign i_win.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_win.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < WIN_TAPS; i++) begin
                r_p1[i] <= n_p1[i];
                r_p2[i] <= n_p2[i];
            end
            r_med <= n_med;
            r_c1  <= i_win.center;
            r_c2  <= r_c1;
            r_c3  <= r_c2;
        end
    end

    assign o_res.valid         = r_v3;
    assign o_res.median_value  = r_med;
    assign o_res.center_column = r_c3.center_column;
    assign o_res.center_row    = r_c3.center_row;
    assign o_res.frame_last    = r_c3.frame_last;

endmodule

`default_nettype wire

@@ rtl/median_filter_3x3_top.sv @@
// Streaming 3x3 median filter for gray pixels in raster order. Takes one pixel word per
// clock with no gaps of its own while the queue accepts windows; each pixel at column
// c >= 2, row r >= 2 yields one result word for the center (c-1, r-1), border pixels
// yield nothing. The front reads the two line stores (two dual-port memories of
// MAX_WIDTH x PIXEL_BITS, read and written every pixel) through a registered read, a
// four-word queue follows, and the median network runs in three register stages; the
// pixel that completes a window passes the front register, the queue and those stages
// before its result word is offered. Line stores need no clearing pass; they hold
// valid data once two rows have gone by. Width and height writes are taken at any
// time but are meant for an idle block; values are clamped to 3..MAX_WIDTH and 3..2048.
`default_nettype none

module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mf3_cfg_if.sink    i_cfg,
    mf3_pix_if.sink    i_pix,
    mf3_res_if.source  o_res
);

    mf3_win_if #(.PIXEL_BITS(PIXEL_BITS)) front_win ();
    mf3_win_if #(.PIXEL_BITS(PIXEL_BITS)) back_win ();

    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_pix   (i_pix),
        .o_win   (front_win)
    );

    mf3_queue #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (front_win),
        .o_win   (back_win)
    );

    mf3_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (back_win),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
